// File: sv/hdx_pkg.sv
// shared types, character codes and hex digit decode for the hex dump byte extractor
`default_nettype none

package hdx_pkg;

	// width of the line limit register
	localparam int unsigned LIMIT_W = 12;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd256;

	// console character codes
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// line parse phases
	typedef enum logic [4:0] {
		PH_SEEK_COLON    = 5'b00001,
		PH_SKIP_SPACES   = 5'b00010,
		PH_HAVE_HIGH     = 5'b00100,
		PH_SKIP_TO_SPACE = 5'b01000,
		PH_STOPPED       = 5'b10000
	} phase_t;

	// decoded hex digit
	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// per-character decision handed from the parser to the output register
	typedef struct packed {
		logic       emit;
		logic [7:0] data_byte;
	} parse_res_t;

	// ascii hex digit decode, either case
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.val = 4'(c - 8'h61 + 8'd10);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.val = 4'(c - 8'h41 + 8'd10);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

`default_nettype wire

// File: sv/hdx_parser.sv
// line parser: phase, pending high nibble and per-line character count
`default_nettype none

module hdx_parser import hdx_pkg::*; #(
	parameter int unsigned COUNT_BITS = 12
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire logic [7:0]         in_char,
	input  wire logic [LIMIT_W-1:0] line_limit,
	output parse_res_t              res
);

	localparam int unsigned CW = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
	localparam logic [CW-1:0] COUNT_MAX = CW'((64'd1 << COUNT_BITS) - 64'd1);

	phase_t                phase_q, phase_d;
	logic [3:0]            high_nibble_q, high_nibble_d;
	logic [COUNT_BITS-1:0] line_count_q, line_count_d;

	hex_t          hex;
	logic [CW-1:0] limit_ext;
	logic [CW-1:0] limit_eff;
	logic          kept;

	// limit capped at the counter range
	assign hex       = hex_decode(in_char);
	assign limit_ext = CW'(line_limit);
	assign limit_eff = (limit_ext > COUNT_MAX) ? COUNT_MAX : limit_ext;
	assign kept      = CW'(line_count_q) < limit_eff;

	// next state and byte decision for the current character
	always_comb begin
		phase_d       = phase_q;
		high_nibble_d = high_nibble_q;
		line_count_d  = line_count_q;
		res.emit      = 1'b0;
		res.data_byte = {high_nibble_q, hex.val};
		if (in_char == CH_CR) begin
			// ignored entirely
		end else if (in_char == CH_LF) begin
			phase_d       = PH_SEEK_COLON;
			high_nibble_d = 4'd0;
			line_count_d  = '0;
		end else if (kept) begin
			line_count_d = line_count_q + COUNT_BITS'(1);
			case (phase_q)
				PH_SEEK_COLON: begin
					if (in_char == CH_COLON)
						phase_d = PH_SKIP_SPACES;
				end
				PH_SKIP_SPACES: begin
					if (in_char != CH_SPACE) begin
						if (hex.ok) begin
							high_nibble_d = hex.val;
							phase_d       = PH_HAVE_HIGH;
						end else begin
							phase_d = PH_STOPPED;
						end
					end
				end
				PH_HAVE_HIGH: begin
					if (hex.ok) begin
						res.emit = 1'b1;
						phase_d  = PH_SKIP_TO_SPACE;
					end else begin
						phase_d = PH_STOPPED;
					end
				end
				PH_SKIP_TO_SPACE: begin
					if (in_char == CH_SPACE)
						phase_d = PH_SKIP_SPACES;
				end
				default: begin
					phase_d = PH_STOPPED;
				end
			endcase
		end
	end

	// state registers, updated once per processed character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SEEK_COLON;
			high_nibble_q <= 4'd0;
			line_count_q  <= '0;
		end else if (fire) begin
			phase_q       <= phase_d;
			high_nibble_q <= high_nibble_d;
			line_count_q  <= line_count_d;
		end
	end

	// a byte only completes from the high-digit phase
	a_emit_from_high: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.emit |-> phase_q == PH_HAVE_HIGH)
		else $error("byte emitted outside high-digit phase");

	// line feed restarts the line
	a_lf_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && in_char == CH_LF |=> line_count_q == '0 && phase_q == PH_SEEK_COLON)
		else $error("line feed did not restart the line");

	// carriage return leaves the line state alone
	a_cr_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		fire && in_char == CH_CR |=> $stable(line_count_q) && $stable(phase_q)
			&& $stable(high_nibble_q))
		else $error("carriage return changed line state");

endmodule

`default_nettype wire

// File: sv/hex_dump_line_byte_extractor.sv
// top level: input register, line parser and output register of the hex dump byte extractor
//
//   channel   dir  width  contents
//   s_*       in   8      s_tdata: in_char
//   m_*       out  8      m_tdata: data_byte
//   cfg_*     in   12     cfg_data: line_limit, written when cfg_we is high
//
// one character per cycle sustained while the output is not held
// a byte's second digit passes the input register, then the parser and the output register
// reset clears the phase, nibble and count, and sets line_limit to 256
// a held result blocks processing of the next character; one more waits in the input register
`default_nettype none

module hex_dump_line_byte_extractor import hdx_pkg::*; #(
	parameter int unsigned COUNT_BITS = 12
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,   // [7:0] in_char
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [7:0]              m_tdata,   // [7:0] data_byte
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_data
);

	logic [LIMIT_W-1:0] line_limit_q;
	logic               valid_s1;
	logic [7:0]         char_s1;
	logic               out_valid_q;
	logic [7:0]         out_data_q;
	logic               out_free;
	logic               proc;
	parse_res_t         res;

	assign out_free = !out_valid_q || m_tready;
	assign proc     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// line limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			line_limit_q <= LIMIT_RESET;
		else if (cfg_we)
			line_limit_q <= cfg_data;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			char_s1 <= s_tdata;
	end

	hdx_parser #(
		.COUNT_BITS(COUNT_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (proc),
		.in_char   (char_s1),
		.line_limit(line_limit_q),
		.res       (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (proc)
			out_valid_q <= res.emit;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (proc && res.emit)
			out_data_q <= res.data_byte;
	end

endmodule

`default_nettype wire

// File: test/tb.sv
// self-checking testbench for the hex dump line byte extractor
`default_nettype none

module tb;
	import hdx_pkg::*;

	// how a directed step is checked
	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_BYTE,
		CHK_SILENT
	} chk_t;

	typedef struct packed {
		logic [7:0] ch;
		chk_t       chk;
		logic [7:0] want;
	} step_t;

	localparam int NUM_STEPS = 27;
	localparam int NUM_PHASES = 8;
	localparam int CHARS_PER_PHASE = 100;
	localparam int DRAIN_CYCLES = 8;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = 8'h00;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [7:0]         m_tdata;
	logic               cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_data = '0;

	// mirror of the line parser
	phase_t             line_phase;
	logic [3:0]         hi_nib;
	logic [11:0]        kept_chars;
	logic [LIMIT_W-1:0] limit_now;

	logic [7:0] pending_bytes [$];
	logic [7:0] line_buf [$];
	step_t      script [0:NUM_STEPS-1];

	int send_gap_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int chars_sent = 0;
	int lines_sent = 0;
	int bytes_seen = 0;
	int limits_used = 1;

	hex_dump_line_byte_extractor DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// run limit
	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// append an expected byte to the scoreboard
	function automatic void queue_byte(input logic [7:0] b);
		pending_bytes = {pending_bytes, b};
	endfunction

	// append a character to the line under construction
	function automatic void add_char(input logic [7:0] c);
		line_buf = {line_buf, c};
	endfunction

	// byte a character completes, if any; advances the mirrored line state
	function automatic bit decode_char(input logic [7:0] c, output logic [7:0] b);
		logic       ok;
		logic [3:0] v;
		b = 8'h00;
		if (c == CH_CR)
			return 1'b0;
		if (c == CH_LF) begin
			line_phase = PH_SEEK_COLON;
			hi_nib = 4'd0;
			kept_chars = '0;
			return 1'b0;
		end
		// limit register is no wider than the counter, so no cap applies
		if (kept_chars >= 12'(limit_now))
			return 1'b0;
		kept_chars = kept_chars + 12'd1;

		ok = (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
		v = (c <= "9") ? c[3:0] : c[3:0] + 4'd9;
		case (line_phase)
			PH_SEEK_COLON: begin
				if (c == CH_COLON)
					line_phase = PH_SKIP_SPACES;
			end
			PH_SKIP_SPACES: begin
				if (c != CH_SPACE) begin
					if (ok) begin
						hi_nib = v;
						line_phase = PH_HAVE_HIGH;
					end else begin
						line_phase = PH_STOPPED;
					end
				end
			end
			PH_HAVE_HIGH: begin
				if (ok) begin
					b = {hi_nib, v};
					line_phase = PH_SKIP_TO_SPACE;
					return 1'b1;
				end
				line_phase = PH_STOPPED;
			end
			PH_SKIP_TO_SPACE: begin
				if (c == CH_SPACE)
					line_phase = PH_SKIP_SPACES;
			end
			default: line_phase = PH_STOPPED;
		endcase
		return 1'b0;
	endfunction

	// one character transfer, with a random gap ahead of it
	task automatic send_char(input logic [7:0] c, input chk_t chk, input logic [7:0] want);
		logic [7:0] b;
		bit         got;
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		do @(posedge clk); while (!s_tready);
		got = decode_char(c, b);
		case (chk)
			CHK_PREDICT: if (got) queue_byte(b);
			CHK_BYTE: queue_byte(want);
			default: ;
		endcase
		chars_sent++;
		@(negedge clk);
	endtask

	// stop sending, let every expected byte arrive and the pipeline empty
	task automatic settle();
		int waited;
		s_tvalid <= 1'b0;
		for (waited = 0; pending_bytes.size() != 0 && waited < 20000; waited++)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10)
			return 8'h30 + 8'(v);
		return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
	endfunction

	// one dump line: mostly well formed, some damaged, some plain noise
	task automatic make_line();
		int kind;
		int n;
		int i;
		int k;
		line_buf.delete();
		kind = $urandom_range(99);
		if (kind >= 88) begin
			n = $urandom_range(20, 1);
			for (i = 0; i < n; i++)
				add_char(8'($urandom_range(255)));
			if ($urandom_range(1))
				add_char(CH_LF);
			return;
		end
		// address field then colon
		n = $urandom_range(8);
		for (i = 0; i < n; i++)
			add_char(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
		add_char(CH_COLON);
		// hex pairs
		n = $urandom_range(16);
		for (i = 0; i < n; i++) begin
			k = $urandom_range(3, (i == 0) ? 0 : 1);
			repeat (k) add_char(CH_SPACE);
			add_char(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
			if ($urandom_range(19) == 0)
				add_char(CH_CR);
			add_char(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
		end
		// ascii column
		if ($urandom_range(1)) begin
			add_char(CH_SPACE);
			add_char(CH_SPACE);
			n = $urandom_range(8);
			for (i = 0; i < n; i++)
				add_char(8'($urandom_range(8'h7E, 8'h21)));
		end
		// damage: overwrite or drop one character
		if (kind >= 70 && line_buf.size() > 1) begin
			k = $urandom_range(line_buf.size() - 1);
			if ($urandom_range(1))
				line_buf[k] = 8'($urandom_range(255));
			else
				line_buf.delete(k);
		end
		if ($urandom_range(3) == 0)
			add_char(CH_CR);
		// some lines run on without a line feed
		if ($urandom_range(9) != 0)
			add_char(CH_LF);
	endtask

	// receiver backpressure
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	// output check against the oldest expected byte
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			bytes_seen++;
			if (pending_bytes.size() == 0)
				report_mismatch($sformatf("byte %02h with none expected", m_tdata));
			else if (m_tdata !== pending_bytes[0])
				report_mismatch($sformatf("data_byte %02h, expected %02h", m_tdata,
					pending_bytes[0]));
			if (pending_bytes.size() != 0)
				void'(pending_bytes.pop_front());
		end
	end

	initial begin
		logic [LIMIT_W-1:0] limits [0:NUM_PHASES-1];
		int p;
		int i;
		int phase_chars;

		limits = '{12'd4095, 12'd1, 12'd24, 12'd0, 12'd7, 12'd256, 12'd60, 12'd2};
		script = '{
			'{8'hFF,    CHK_SILENT, 8'h00},  // top byte ahead of the colon
			'{"A",      CHK_SILENT, 8'h00},
			'{CH_COLON, CHK_SILENT, 8'h00},
			'{CH_SPACE, CHK_SILENT, 8'h00},
			'{"f",      CHK_SILENT, 8'h00},
			'{"F",      CHK_BYTE,   8'hFF},
			'{CH_SPACE, CHK_SILENT, 8'h00},
			'{"0",      CHK_SILENT, 8'h00},
			'{"0",      CHK_BYTE,   8'h00},
			'{"x",      CHK_SILENT, 8'h00},  // skipped up to the next space
			'{CH_COLON, CHK_SILENT, 8'h00},  // later colon is ordinary
			'{CH_SPACE, CHK_SILENT, 8'h00},
			'{"a",      CHK_SILENT, 8'h00},
			'{CH_CR,    CHK_SILENT, 8'h00},  // carriage return inside a pair
			'{"B",      CHK_BYTE,   8'hAB},
			'{CH_SPACE, CHK_SILENT, 8'h00},
			'{"9",      CHK_SILENT, 8'h00},
			'{"g",      CHK_SILENT, 8'h00},  // non-hex stops the line
			'{"1",      CHK_SILENT, 8'h00},
			'{"2",      CHK_SILENT, 8'h00},
			'{CH_LF,    CHK_SILENT, 8'h00},
			'{CH_COLON, CHK_SILENT, 8'h00},
			'{8'h00,    CHK_SILENT, 8'h00},  // nul where a digit belongs
			'{CH_LF,    CHK_SILENT, 8'h00},
			'{CH_COLON, CHK_SILENT, 8'h00},
			'{"7",      CHK_SILENT, 8'h00},  // lone digit dropped at line end
			'{CH_LF,    CHK_SILENT, 8'h00}
		};

		line_phase = PH_SEEK_COLON;
		hi_nib = 4'd0;
		kept_chars = '0;
		limit_now = LIMIT_RESET;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed lines at the reset limit
		for (i = 0; i < NUM_STEPS; i++)
			send_char(script[i].ch, script[i].chk, script[i].want);
		lines_sent += 3;

		// random lines under each limit and idling pattern
		for (p = 0; p < NUM_PHASES; p++) begin
			settle();
			cfg_we <= 1'b1;
			cfg_data <= limits[p];
			@(negedge clk);
			cfg_we <= 1'b0;
			limit_now = limits[p];
			limits_used++;
			case (p % 4)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 46; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 46; end
				default: begin send_gap_pct = 34; stall_pct = 34; end
			endcase
			phase_chars = 0;
			while (phase_chars < CHARS_PER_PHASE) begin
				make_line();
				foreach (line_buf[j])
					send_char(line_buf[j], CHK_PREDICT, 8'h00);
				phase_chars += line_buf.size();
				lines_sent++;
			end
		end

		settle();
		if (pending_bytes.size() != 0)
			report_mismatch($sformatf("%0d expected bytes never came", pending_bytes.size()));

		$display("run covered %0d characters in %0d lines under %0d line limits",
			chars_sent, lines_sent, limits_used);
		$display("%0d data bytes compared, %0d mismatches", bytes_seen, mismatches);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
sv/hdx_pkg.sv
sv/hdx_parser.sv
sv/hex_dump_line_byte_extractor.sv
test/tb.sv
